// ===== hdl/frame_peak_audio_agc_core_macros.svh =====
// assertion macros used by the agc datapath
`ifndef FRAME_PEAK_AUDIO_AGC_CORE_MACROS_SVH
`define FRAME_PEAK_AUDIO_AGC_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define FPAGC_CHECK(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("agc check failed");
`define FPAGC_CHECK_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("agc check failed");
`else
`define FPAGC_CHECK(lbl, prop)
`define FPAGC_CHECK_ALWAYS(lbl, prop)
`endif
`endif

// ===== hdl/fpagc_pkg.sv =====
// shared types and constants of the frame peak agc
package fpagc_pkg;
  localparam int SAMPLE_W       = 16;
  localparam int GAIN_W         = 22;
  localparam int DIV_NUM_W      = 31;
  localparam int DIV_DEN_W      = 17;
  localparam int FRAME_LEN_DEF  = 160;
  localparam int HIST_DEPTH_DEF = 25;
  localparam int LIMIT_DIV      = 20;

  localparam logic [GAIN_W-1:0]    GAIN_MAX   = 22'd3276800;
  localparam logic [GAIN_W-1:0]    GAIN_RESET = 22'd1638400;
  localparam logic [DIV_NUM_W-1:0] TARGET_NUM = 31'd1966080000;

  // reciprocal multiply for gain / 20, exact for any 22-bit gain
  localparam int LIM_SHIFT = 27;
  localparam int LIM_MUL_W = 23;
  localparam logic [LIM_MUL_W-1:0] LIM_MUL =
    LIM_MUL_W'(((64'd1 << LIM_SHIFT) + 64'(LIMIT_DIV) - 64'd1) / 64'(LIMIT_DIV));

  // reciprocal multiply for rise / frame length, exact for rise below 2^18
  localparam int RAMP_SHIFT = 28;
  localparam int RAMP_MUL_W = 26;

  localparam logic [1:0] MODE_AUTO   = 2'd0;
  localparam logic [1:0] MODE_FIXED  = 2'd1;
  localparam logic [1:0] MODE_BYPASS = 2'd2;
  localparam logic [1:0] MODE_SPARE  = 2'd3;

  localparam logic CFG_MODE  = 1'b0;
  localparam logic CFG_FIXED = 1'b1;

  typedef struct packed {
    logic       accept;
    logic       calc_gain;
    logic       mul;
    logic       emit;
    logic       fd_start;
    logic       scan_step;
    logic       div_start;
    logic       target_max;
    logic       take_quot;
    logic       apply_low;
    logic       set_rise;
    logic       set_lim;
    logic       set_ramp;
  } cmd_t;

  typedef struct packed {
    logic frame_ready;
    logic last;
    logic auto_mode;
    logic out_free;
    logic scan_last;
    logic peak_zero;
    logic div_done;
    logic target_low;
  } stat_t;
endpackage

// ===== hdl/frame_peak_audio_agc_core.sv =====
// top level of the frame peak audio agc
// usage:
//   in_*  : one 16-bit signed sample per beat (valid/ready)
//   out_* : scaled sample of the previous frame, clip flag, frame end flag
//   cfg_* : register writes, index 0 gain mode, index 1 fixed gain (Q6.16),
//           always ready, write only while the block is idle
// latency: the first result appears only after a whole frame has been taken;
//   from then on each accepted sample releases one sample of the prior frame
// per sample: store read, gain, multiply, output (held while the output register
//   is full); the last sample of a frame in automatic mode adds the history scan,
//   one serial divide for the target (skipped when the peak is zero) and five
//   further steps (the last two only when the target is not below the gain);
//   fixed or bypass mode adds only the frame-end step
// reset: gain 25.0, history and peak cleared, automatic mode, no frame held;
//   the frame store needs no clearing since each entry is written before use
// stall: a finished beat waits in the output register; the next sample is
//   still accepted and worked until its own result needs that register
module frame_peak_audio_agc_core #(
  parameter int FRAME_LEN     = fpagc_pkg::FRAME_LEN_DEF,
  parameter int HISTORY_DEPTH = fpagc_pkg::HIST_DEPTH_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [fpagc_pkg::SAMPLE_W-1:0] in_sample_in,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [fpagc_pkg::SAMPLE_W-1:0] out_sample_out,
  output logic                                  out_clipped,
  output logic                                  out_frame_end,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic                                  cfg_index,
  input  logic [fpagc_pkg::GAIN_W-1:0]          cfg_data
);
  import fpagc_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // register writes are always accepted
  assign cfg_ready = 1'b1;

  // sequencer: walks each sample and the frame-end update
  fpagc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // storage, arithmetic and the output register
  fpagc_datapath #(
    .FRAME_LEN     (FRAME_LEN),
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .stat           (stat),
    .in_sample_in   (in_sample_in),
    .cfg_valid      (cfg_valid),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_sample_out (out_sample_out),
    .out_clipped    (out_clipped),
    .out_frame_end  (out_frame_end)
  );
endmodule

// ===== hdl/fpagc_div.sv =====
// serial restoring divider, one quotient bit per cycle
module fpagc_div (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic [fpagc_pkg::DIV_NUM_W-1:0] num,
  input  logic [fpagc_pkg::DIV_DEN_W-1:0] den,
  output logic                            done,
  output logic [fpagc_pkg::DIV_NUM_W-1:0] quot
);
  import fpagc_pkg::*;

  localparam int CW = $clog2(DIV_NUM_W);

  logic [DIV_DEN_W-1:0] rem_r;
  logic [DIV_DEN_W-1:0] den_r;
  logic [DIV_NUM_W-1:0] quot_r;
  logic [CW-1:0]        cnt_r;
  logic                 busy_r;
  logic                 done_r;
  logic [DIV_DEN_W:0]   rem_sh;
  logic                 fits;

  assign rem_sh = {rem_r, quot_r[DIV_NUM_W-1]};
  assign fits   = rem_sh >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 1'b1;
      if (cnt_r == CW'(DIV_NUM_W-1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end else begin
      done_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r  <= '0;
      den_r  <= den;
      quot_r <= num;
    end else if (busy_r) begin
      rem_r  <= fits ? DIV_DEN_W'(rem_sh - {1'b0, den_r}) : rem_sh[DIV_DEN_W-1:0];
      quot_r <= {quot_r[DIV_NUM_W-2:0], fits};
    end
  end

  assign done = done_r;
  assign quot = quot_r;
endmodule

// ===== hdl/fpagc_datapath.sv =====
// agc datapath: frame store, gain, scaling, peak history and output register
`include "frame_peak_audio_agc_core_macros.svh"
module fpagc_datapath #(
  parameter int FRAME_LEN     = fpagc_pkg::FRAME_LEN_DEF,
  parameter int HISTORY_DEPTH = fpagc_pkg::HIST_DEPTH_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  fpagc_pkg::cmd_t                       cmd,
  output fpagc_pkg::stat_t                      stat,
  input  logic signed [fpagc_pkg::SAMPLE_W-1:0] in_sample_in,
  input  logic                                  cfg_valid,
  input  logic                                  cfg_index,
  input  logic [fpagc_pkg::GAIN_W-1:0]          cfg_data,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [fpagc_pkg::SAMPLE_W-1:0] out_sample_out,
  output logic                                  out_clipped,
  output logic                                  out_frame_end
);
  import fpagc_pkg::*;

  localparam int PW   = $clog2(FRAME_LEN);
  localparam int FLW  = $clog2(FRAME_LEN + 1);
  localparam int HW   = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int RW   = PW + GAIN_W;
  localparam int EW   = FLW + GAIN_W;
  localparam int PRW  = SAMPLE_W + 1 + GAIN_W - 16;
  localparam logic [RAMP_MUL_W-1:0] RAMP_MUL =
    RAMP_MUL_W'(((64'd1 << RAMP_SHIFT) + 64'(FRAME_LEN) - 64'd1) / 64'(FRAME_LEN));

  // configuration
  logic [1:0]        mode_r;
  logic [GAIN_W-1:0] fixed_r;

  // per-sample state
  logic [SAMPLE_W-1:0] sample_r;
  logic [SAMPLE_W-1:0] mem_q;
  logic [SAMPLE_W-1:0] frame_mem [FRAME_LEN];
  logic [PW-1:0]       pos_r;
  logic                frame_ready_r;
  logic [GAIN_W-1:0]   gain_r;
  logic [PRW-1:0]      prod_r;
  logic [SAMPLE_W-1:0] peak_r;

  // gain state
  logic [GAIN_W-1:0]    cur_r;
  logic [GAIN_W-1:0]    ramp_r;
  logic [SAMPLE_W-1:0]  hist_r [HISTORY_DEPTH];
  logic [HW-1:0]        slot_r;
  logic [HW-1:0]        scan_r;
  logic [SAMPLE_W-1:0]  max_r;
  logic [DIV_NUM_W-1:0] target_r;
  logic [GAIN_W-1:0]    rise_r;

  // output register
  logic                out_valid_r;
  logic [SAMPLE_W-1:0] out_sample_r;
  logic                out_clip_r;
  logic                out_end_r;

  logic                 last;
  logic [SAMPLE_W:0]    old_ext;
  logic [SAMPLE_W:0]    old_mag;
  logic [SAMPLE_W:0]    in_ext;
  logic [SAMPLE_W:0]    in_mag;
  logic [RW-1:0]        ramp_off;
  logic [RW:0]          ramp_sum;
  logic [GAIN_W-1:0]    fixed_cl;
  logic [EW-1:0]        end_off;
  logic [EW:0]          end_sum;
  logic [GAIN_W-1:0]    end_gain;
  logic [SAMPLE_W-1:0]  y;
  logic                 clip;
  logic                 div_done;
  logic [DIV_NUM_W-1:0] quot;
  logic [GAIN_W-1:0]    lim;
  logic [DIV_NUM_W-1:0] div_num;
  logic [DIV_DEN_W-1:0] div_den;
  logic [GAIN_W-1:0]    tgt_cl;
  logic [GAIN_W+LIM_MUL_W-1:0]  lim_prod;
  logic [GAIN_W-1:0]            lim_cur;
  logic [GAIN_W+RAMP_MUL_W-1:0] ramp_prod;
  logic [GAIN_W-1:0]            ramp_q;

  assign last = pos_r == PW'(FRAME_LEN - 1);

  assign old_ext = {mem_q[SAMPLE_W-1], mem_q};
  assign old_mag = mem_q[SAMPLE_W-1] ? (~old_ext + 1'b1) : old_ext;
  assign in_ext  = {sample_r[SAMPLE_W-1], sample_r};
  assign in_mag  = sample_r[SAMPLE_W-1] ? (~in_ext + 1'b1) : in_ext;

  assign ramp_off = {{GAIN_W{1'b0}}, pos_r} * {{PW{1'b0}}, ramp_r};
  assign ramp_sum = {1'b0, ramp_off} + (RW + 1)'(cur_r);
  assign fixed_cl = (fixed_r > GAIN_MAX) ? GAIN_MAX : fixed_r;

  assign end_off  = EW'(FRAME_LEN) * EW'(ramp_r);
  assign end_sum  = {1'b0, end_off} + (EW + 1)'(cur_r);
  assign end_gain = (end_sum > (EW + 1)'(GAIN_MAX)) ? GAIN_MAX : end_sum[GAIN_W-1:0];

  // saturate the scaled magnitude back to a signed sample; bypass and spare modes pass the stored sample
  always_comb begin
    clip = 1'b0;
    if (mode_r != MODE_AUTO && mode_r != MODE_FIXED) begin
      y = mem_q;
    end else if (mem_q[SAMPLE_W-1]) begin
      if (prod_r > PRW'(32768)) begin
        y    = {1'b1, {(SAMPLE_W-1){1'b0}}};
        clip = 1'b1;
      end else begin
        y = ~prod_r[SAMPLE_W-1:0] + 1'b1;
      end
    end else if (prod_r > PRW'(32767)) begin
      y    = {1'b0, {(SAMPLE_W-1){1'b1}}};
      clip = 1'b1;
    end else begin
      y = prod_r[SAMPLE_W-1:0];
    end
  end

  assign tgt_cl = (target_r > DIV_NUM_W'(GAIN_MAX)) ? GAIN_MAX : target_r[GAIN_W-1:0];

  // 5% rise limit and per-sample ramp step by reciprocal multiplies
  assign lim_prod  = (GAIN_W + LIM_MUL_W)'(cur_r) * (GAIN_W + LIM_MUL_W)'(LIM_MUL);
  assign lim_cur   = GAIN_W'(lim_prod >> LIM_SHIFT);
  assign lim       = (lim_cur < rise_r) ? lim_cur : rise_r;
  assign ramp_prod = (GAIN_W + RAMP_MUL_W)'(rise_r) * (GAIN_W + RAMP_MUL_W)'(RAMP_MUL);
  assign ramp_q    = GAIN_W'(ramp_prod >> RAMP_SHIFT);

  // target gain = 30000.0 / history peak
  assign div_num = TARGET_NUM;
  assign div_den = {1'b0, max_r};

  fpagc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (quot)
  );

  // frame store
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      mem_q <= frame_mem[pos_r];
    end
    if (cmd.emit) begin
      frame_mem[pos_r] <= sample_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      sample_r <= in_sample_in;
    end
    if (cmd.calc_gain) begin
      if (mode_r == MODE_FIXED) begin
        gain_r <= fixed_cl;
      end else begin
        gain_r <= (ramp_sum > (RW + 1)'(GAIN_MAX)) ? GAIN_MAX : ramp_sum[GAIN_W-1:0];
      end
    end
    if (cmd.mul) begin
      prod_r <= PRW'(({{GAIN_W{1'b0}}, old_mag} * {{(SAMPLE_W+1){1'b0}}, gain_r}) >> 16);
    end
    if (cmd.emit && frame_ready_r) begin
      out_sample_r <= y;
      out_clip_r   <= clip;
      out_end_r    <= last;
    end
    if (cmd.fd_start) begin
      max_r <= peak_r;
    end else if (cmd.scan_step && hist_r[scan_r] > max_r) begin
      max_r <= hist_r[scan_r];
    end
    if (cmd.target_max) begin
      target_r <= DIV_NUM_W'(GAIN_MAX);
    end else if (cmd.take_quot) begin
      target_r <= quot;
    end
    if (cmd.set_rise) begin
      rise_r <= tgt_cl - cur_r;
    end else if (cmd.set_lim) begin
      rise_r <= lim;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r        <= MODE_AUTO;
      fixed_r       <= GAIN_RESET;
      pos_r         <= '0;
      frame_ready_r <= 1'b0;
      peak_r        <= '0;
      cur_r         <= GAIN_RESET;
      ramp_r        <= '0;
      slot_r        <= '0;
      scan_r        <= '0;
      out_valid_r   <= 1'b0;
      for (int i = 0; i < HISTORY_DEPTH; i++) begin
        hist_r[i] <= '0;
      end
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          CFG_MODE:  mode_r  <= cfg_data[1:0];
          CFG_FIXED: fixed_r <= cfg_data;
          default:   mode_r  <= mode_r;
        endcase
      end
      if (cmd.emit && frame_ready_r) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cmd.emit) begin
        if (frame_ready_r && last) begin
          cur_r <= end_gain;
        end
        if (last) begin
          pos_r         <= '0;
          frame_ready_r <= 1'b1;
        end else begin
          pos_r <= pos_r + 1'b1;
        end
        if (in_mag[SAMPLE_W-1:0] > peak_r) begin
          peak_r <= in_mag[SAMPLE_W-1:0];
        end
      end
      if (cmd.fd_start) begin
        ramp_r <= '0;
        peak_r <= '0;
        scan_r <= '0;
        if (mode_r == MODE_AUTO) begin
          hist_r[slot_r] <= peak_r;
          slot_r <= (slot_r == HW'(HISTORY_DEPTH - 1)) ? '0 : slot_r + 1'b1;
        end
      end
      if (cmd.scan_step) begin
        scan_r <= scan_r + 1'b1;
      end
      if (cmd.apply_low) begin
        cur_r <= target_r[GAIN_W-1:0];
      end
      if (cmd.set_ramp) begin
        ramp_r <= ramp_q;
      end
    end
  end

  assign stat.frame_ready = frame_ready_r;
  assign stat.last        = last;
  assign stat.auto_mode   = mode_r == MODE_AUTO;
  assign stat.out_free    = !out_valid_r || out_ready;
  assign stat.scan_last   = scan_r == HW'(HISTORY_DEPTH - 1);
  assign stat.peak_zero   = max_r == '0;
  assign stat.div_done    = div_done;
  assign stat.target_low  = target_r < DIV_NUM_W'(cur_r);

  assign out_valid      = out_valid_r;
  assign out_sample_out = out_sample_r;
  assign out_clipped    = out_clip_r;
  assign out_frame_end  = out_end_r;

  `FPAGC_CHECK(a_no_out_before_frame, $rose(out_valid_r) |-> frame_ready_r)
  `FPAGC_CHECK(a_gain_capped, cur_r <= GAIN_MAX)
  `FPAGC_CHECK(a_pos_in_frame, pos_r <= PW'(FRAME_LEN - 1))
  `FPAGC_CHECK(a_out_held, (out_valid_r && !out_ready) |=> $stable(out_sample_r))
endmodule

// ===== hdl/fpagc_ctrl.sv =====
// agc sequencer: per-sample steps and frame-end gain update
module fpagc_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  fpagc_pkg::stat_t  stat,
  output fpagc_pkg::cmd_t   cmd
);
  import fpagc_pkg::*;

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_GAIN  = 4'd1;
  localparam logic [3:0] ST_MUL   = 4'd2;
  localparam logic [3:0] ST_OUT   = 4'd3;
  localparam logic [3:0] ST_HIST  = 4'd4;
  localparam logic [3:0] ST_SCAN  = 4'd5;
  localparam logic [3:0] ST_TSTRT = 4'd6;
  localparam logic [3:0] ST_TWAIT = 4'd7;
  localparam logic [3:0] ST_TCMP  = 4'd8;
  localparam logic [3:0] ST_LWAIT = 4'd9;
  localparam logic [3:0] ST_RWAIT = 4'd10;

  logic [3:0] state_r;
  logic [3:0] state_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = ST_GAIN;
        end
      end
      ST_GAIN: begin
        cmd.calc_gain = 1'b1;
        state_nxt     = ST_MUL;
      end
      ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (!stat.frame_ready || stat.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = stat.last ? ST_HIST : ST_IDLE;
        end
      end
      ST_HIST: begin
        cmd.fd_start = 1'b1;
        state_nxt    = stat.auto_mode ? ST_SCAN : ST_IDLE;
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (stat.scan_last) begin
          state_nxt = ST_TSTRT;
        end
      end
      ST_TSTRT: begin
        if (stat.peak_zero) begin
          cmd.target_max = 1'b1;
          state_nxt      = ST_TCMP;
        end else begin
          cmd.div_start = 1'b1;
          state_nxt     = ST_TWAIT;
        end
      end
      ST_TWAIT: begin
        if (stat.div_done) begin
          cmd.take_quot = 1'b1;
          state_nxt     = ST_TCMP;
        end
      end
      ST_TCMP: begin
        if (stat.target_low) begin
          cmd.apply_low = 1'b1;
          state_nxt     = ST_IDLE;
        end else begin
          cmd.set_rise = 1'b1;
          state_nxt    = ST_LWAIT;
        end
      end
      ST_LWAIT: begin
        cmd.set_lim = 1'b1;
        state_nxt   = ST_RWAIT;
      end
      ST_RWAIT: begin
        cmd.set_ramp = 1'b1;
        state_nxt    = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end
endmodule
